### rtl/fls_pkg.sv
// ----------------------------------------------------------------------------
// Failover leader selector package
// Table size, field widths and the named codes shared by the selector logic.
// ----------------------------------------------------------------------------
package fls_pkg;

  // Number of member slots in the table.
  localparam int MEMBERS  = 16;
  // Slot index width and leader width (the leader can also hold MEMBERS).
  localparam int IDX_W    = $clog2(MEMBERS);
  localparam int LEADER_W = $clog2(MEMBERS + 1);
  localparam int MSG_W    = 32;

  // Action codes carried by an input word.
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_SELECT = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;

  // Status codes carried by a result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_LIVE   = 2'd1;
  localparam logic [1:0] ST_NO_LEADER = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WILDCARD  = 2'd0;
  localparam logic [1:0] CFG_INIT_LEAD = 2'd1;
  localparam logic [1:0] CFG_LAG_TRIG  = 2'd2;

  // Leader value that means no valid leader.
  localparam logic [LEADER_W-1:0] LEADER_NONE = LEADER_W'(MEMBERS);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SEL_SCAN = 6'b000010,
    S_CHK_LEAD = 6'b000100,
    S_CHK_SCAN = 6'b001000,
    S_CHK_END  = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

endpackage

### rtl/failover_leader_selector.sv
// ----------------------------------------------------------------------------
// Failover leader selector
// Member table with present, failed and message-number fields, a current
// leader, and a small sequencer that selects a leader or checks it for lag.
// ----------------------------------------------------------------------------
// One input word is taken at a time and gives one result word. An update
// goes straight to the result. A select scans the table one slot per cycle
// from the current leader upwards with wrap-round, until a live member turns
// up or every slot has been tried; in wildcard mode it goes straight to the
// result. A check reads the leader's message number, then passes every slot
// once through the single subtract-and-compare unit, or goes straight to the
// result when there is no usable leader. The input is stalled from acceptance
// until the result leaves the sequencer. The result register is separate from
// the sequencer, so a result may wait on out_stall while the next word is
// accepted; the sequencer then holds its result until the register is free.
// Configuration writes are always taken (cfg_ready is high) and are meant to
// be made only while the block is idle.
module failover_leader_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [3:0]                    in_member_index,
  input  logic                          in_member_present,
  input  logic                          in_member_failed,
  input  logic [31:0]                   in_msg_number,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [fls_pkg::LEADER_W-1:0]  out_leader_index,
  output logic                          out_leader_known,
  output logic                          out_leader_failed,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import fls_pkg::*;

  // Configuration registers.
  logic                wildcard_r;
  logic [MSG_W-1:0]    lag_trigger_r;

  // Member table and leader.
  logic [MEMBERS-1:0]  present_r, present_nxt;
  logic [MEMBERS-1:0]  failed_r, failed_nxt;
  logic [MSG_W-1:0]    msg_r [MEMBERS];
  logic [LEADER_W-1:0] leader_r, leader_nxt;

  // Sequencer and scan datapath.
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [MSG_W-1:0]    lead_msg_r, lead_msg_nxt;
  logic [MSG_W-1:0]    max_lag_r, max_lag_nxt;
  logic                found_r, found_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                lfail_r, lfail_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [LEADER_W-1:0] out_leader_r;
  logic                out_known_r;
  logic                out_lfail_r;

  // Helper signals.
  logic                in_accept;
  logic                cfg_write;
  logic                leader_valid;
  logic [IDX_W-1:0]    leader_idx;
  logic                leader_usable;
  logic [MEMBERS-1:0]  live;
  logic [IDX_W-1:0]    rd_idx;
  logic [MSG_W-1:0]    rd_msg;
  logic [MSG_W:0]      diff;
  logic                ahead;
  logic                slot_wr;
  logic [IDX_W-1:0]    wr_idx;
  logic                res_move;
  logic [LEADER_W-1:0] init_leader;
  logic                ptr_last;
  logic [IDX_W-1:0]    ptr_inc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Leader decoding and slot liveness.
  assign leader_valid  = (leader_r < LEADER_NONE);
  assign leader_idx    = leader_r[IDX_W-1:0];
  assign leader_usable = !wildcard_r && leader_valid && present_r[leader_idx];
  assign live          = present_r & ~failed_r;

  // Single read port of the message table: the leader first, then the scan.
  assign rd_idx = (state_r == S_CHK_LEAD) ? leader_idx : ptr_r;
  assign rd_msg = msg_r[rd_idx];

  // Shared subtractor: a member is ahead when its number is strictly greater.
  assign diff  = {1'b0, rd_msg} - {1'b0, lead_msg_r};
  assign ahead = !diff[MSG_W] && (diff[MSG_W-1:0] != '0);

  assign ptr_last = (ptr_r == IDX_W'(MEMBERS - 1));
  assign ptr_inc  = ptr_last ? '0 : ptr_r + 1'b1;

  // A written initial leader outside the table (judged on its low LEADER_W bits) means no leader.
  assign init_leader = (cfg_data[LEADER_W-1:0] >= LEADER_NONE) ? LEADER_NONE
                                                               : cfg_data[LEADER_W-1:0];

  assign wr_idx  = in_member_index[IDX_W-1:0];
  assign slot_wr = in_accept && (in_action == ACT_UPDATE) &&
                   (32'(in_member_index) < MEMBERS);

  assign res_move = (state_r == S_RESULT) && (!out_valid_r || !out_stall);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    present_nxt  = present_r;
    failed_nxt   = failed_r;
    leader_nxt   = leader_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    lead_msg_nxt = lead_msg_r;
    max_lag_nxt  = max_lag_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    lfail_nxt    = lfail_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          status_nxt = ST_OK;
          lfail_nxt  = 1'b0;
          state_nxt  = S_RESULT;
          case (in_action)
            ACT_UPDATE: begin
              if (slot_wr) begin
                present_nxt[wr_idx] = in_member_present;
                failed_nxt[wr_idx]  = in_member_failed;
              end
            end
            ACT_SELECT: begin
              if (!wildcard_r) begin
                ptr_nxt   = leader_valid ? leader_idx : '0;
                cnt_nxt   = '0;
                state_nxt = S_SEL_SCAN;
              end
            end
            ACT_CHECK: begin
              if (leader_usable) begin
                state_nxt = S_CHK_LEAD;
              end else begin
                status_nxt = ST_NO_LEADER;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      // Walk the slots with wrap-round until a live member turns up or every slot has been tried.
      S_SEL_SCAN: begin
        if (live[ptr_r]) begin
          leader_nxt = LEADER_W'(ptr_r);
          state_nxt  = S_RESULT;
        end else if (cnt_r == IDX_W'(MEMBERS - 1)) begin
          leader_nxt = LEADER_NONE;
          status_nxt = ST_NO_LIVE;
          state_nxt  = S_RESULT;
        end else begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Latch the leader's message number as the lag reference.
      S_CHK_LEAD: begin
        lead_msg_nxt = rd_msg;
        ptr_nxt      = '0;
        found_nxt    = 1'b0;
        max_lag_nxt  = '0;
        state_nxt    = S_CHK_SCAN;
      end

      // Keep the largest lag of the other live members ahead of the leader.
      S_CHK_SCAN: begin
        if (live[ptr_r] && (ptr_r != leader_idx) && ahead &&
            (!found_r || (diff[MSG_W-1:0] > max_lag_r))) begin
          max_lag_nxt = diff[MSG_W-1:0];
          found_nxt   = 1'b1;
        end
        if (ptr_last) begin
          state_nxt = S_CHK_END;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      // Mark the leader failed when the worst lag passes the trigger.
      S_CHK_END: begin
        if (found_r && (max_lag_r > lag_trigger_r)) begin
          failed_nxt[leader_idx] = 1'b1;
          lfail_nxt              = 1'b1;
        end
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        if (res_move) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A leader write from the configuration port reloads the leader.
    if (cfg_write && (cfg_index == CFG_INIT_LEAD)) begin
      leader_nxt = init_leader;
    end
  end

  // Result register: loaded from the sequencer, emptied by the receiver.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      present_r     <= '0;
      failed_r      <= '0;
      leader_r      <= LEADER_NONE;
      wildcard_r    <= 1'b0;
      lag_trigger_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      failed_r    <= failed_nxt;
      leader_r    <= leader_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write && (cfg_index == CFG_WILDCARD)) begin
        wildcard_r <= cfg_data[0];
      end
      if (cfg_write && (cfg_index == CFG_LAG_TRIG)) begin
        lag_trigger_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    cnt_r      <= cnt_nxt;
    lead_msg_r <= lead_msg_nxt;
    max_lag_r  <= max_lag_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    lfail_r    <= lfail_nxt;
    if (slot_wr) begin
      msg_r[wr_idx] <= in_msg_number;
    end
    if (res_move) begin
      out_status_r <= status_r;
      out_leader_r <= leader_r;
      out_known_r  <= leader_usable;
      out_lfail_r  <= lfail_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_leader_index  = out_leader_r;
  assign out_leader_known  = out_known_r;
  assign out_leader_failed = out_lfail_r;

  // Checks on the sequencer and the result word.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_leader_range: assert property (@(posedge clk) disable iff (!rst_n)
    leader_r <= LEADER_NONE)
    else $error("leader index beyond the table");

  a_no_live_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_NO_LIVE) |-> (out_leader_r == LEADER_NONE))
    else $error("no live member reported with a valid leader");

  a_fail_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lfail_r |-> (out_status_r == ST_OK) && !out_known_r ||
    out_valid_r && out_lfail_r && (out_status_r == ST_OK))
    else $error("leader failure reported with a bad status");

  a_fail_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK_END) && lfail_nxt |=> failed_r[$past(leader_idx)])
    else $error("failed leader not marked in the table");

  a_scan_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK_LEAD) |-> ($past(state_r) == S_IDLE) && leader_usable)
    else $error("check scan started without a usable leader");

endmodule
